// ----- design/dre_pkg.sv -----
package dre_pkg;

    localparam logic [7:0] QuietLevel    = 8'h80;
    localparam logic [7:0] RunFull       = 8'hff;
    localparam logic [7:0] RunMarker     = 8'h00;
    localparam logic [7:0] ZeroEscape    = 8'h01;
    localparam logic [6:0] DeadbandReset = 7'd5;

    // one item's worth of result bytes, sent in order from byte 0
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            eos;
    } t_grp;

endpackage

// ----- design/dre_in_if.sv -----
interface dre_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;
    logic       final_sample;

    modport source(output valid, output sample, output final_sample, input ready);
    modport sink(input valid, input sample, input final_sample, output ready);
endinterface

// ----- design/dre_out_if.sv -----
interface dre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       end_of_stream;

    modport source(output valid, output out_byte, output last_of_item,
                   output end_of_stream, input ready);
    modport sink(input valid, input out_byte, input last_of_item,
                 input end_of_stream, output ready);
endinterface

// ----- design/dre_enc.sv -----
module dre_enc (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [6:0]    i_cfg_wdata,
    input  logic          i_acc,
    input  logic [7:0]    i_sample,
    input  logic          i_final,
    output dre_pkg::t_grp o_grp
);
    import dre_pkg::*;

    logic [6:0] r_deadband;
    logic [7:0] r_run;
    logic [7:0] n_run;
    logic [7:0] r_held;
    logic [7:0] n_held;
    logic [7:0] run_inc;
    logic [7:0] esc;
    logic       in_band;
    t_grp       grp;

    assign esc     = (i_sample == 8'd0) ? ZeroEscape : i_sample;
    assign run_inc = r_run + 8'd1;
    assign in_band = ({1'b0, i_sample} <= ({1'b0, QuietLevel} + {2'b00, r_deadband}))
                  && (({1'b0, i_sample} + {2'b00, r_deadband}) >= {1'b0, QuietLevel});

    always_comb begin
        grp    = '0;
        n_run  = r_run;
        n_held = r_held;
        if (!i_final && in_band) begin
            n_held = i_sample;
            if (run_inc == RunFull) begin
                grp.cnt      = 2'd2;
                grp.bytes[0] = RunMarker;
                grp.bytes[1] = RunFull;
                n_run        = 8'd0;
            end else begin
                n_run = run_inc;
            end
        end else begin
            // flush pending run, then the escaped sample
            n_run = 8'd0;
            priority if (r_run == 8'd0) begin
                grp.cnt      = 2'd1;
                grp.bytes[0] = esc;
            end else if (r_run == 8'd1) begin
                grp.cnt      = 2'd2;
                grp.bytes[0] = r_held;
                grp.bytes[1] = esc;
            end else begin
                grp.cnt      = 2'd3;
                grp.bytes[0] = RunMarker;
                grp.bytes[1] = r_run;
                grp.bytes[2] = esc;
            end
            if (i_final) begin
                grp.eos = 1'b1;
                n_held  = 8'd0;
            end
        end
    end

    assign o_grp = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DeadbandReset;
            r_run      <= 8'd0;
            r_held     <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_deadband <= i_cfg_wdata;
            end
            if (i_acc) begin
                r_run  <= n_run;
                r_held <= n_held;
            end
        end
    end

    a_run_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run != RunFull) else $error("pending run reached full count");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_final) |=> (r_run == 8'd0 && r_held == 8'd0))
        else $error("final sample did not clear state");

    a_quiet_no_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_final) |-> !o_grp.eos) else $error("end of stream without final sample");
endmodule

// ----- design/dre_ser.sv -----
module dre_ser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  dre_pkg::t_grp i_grp,
    input  logic          i_out_ready,
    output logic          o_free,
    output logic          o_valid,
    output logic [7:0]    o_byte,
    output logic          o_last,
    output logic          o_eos
);
    import dre_pkg::*;

    logic            r_valid;
    logic [2:0][7:0] r_bytes;
    logic [1:0]      r_cnt;
    logic            r_eos;
    logic [1:0]      r_idx;
    logic            last;
    logic            take;

    assign last    = (r_idx == (r_cnt - 2'd1));
    assign take    = r_valid && i_out_ready;
    assign o_free  = !r_valid || (take && last);
    assign o_valid = r_valid;
    assign o_byte  = r_bytes[r_idx];
    assign o_last  = last;
    assign o_eos   = r_eos && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (take) begin
            if (last) begin
                r_valid <= 1'b0;
                r_idx   <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_grp.bytes;
            r_cnt   <= i_grp.cnt;
            r_eos   <= i_grp.eos;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free) else $error("group loaded over pending bytes");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < r_cnt)) else $error("byte index past group");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && last && !i_load) |=> !r_valid) else $error("group not retired");
endmodule

// ----- design/deadband_rle_audio_encoder_unit.sv -----
// deadband run-length audio encoder
// i_in carries unsigned 8-bit samples (0x80 is silence) with a final_sample flag;
// o_out carries encoded bytes, one per transaction, with last_of_item on the last
// byte caused by a sample and end_of_stream on the last byte of a final sample.
// i_cfg_we/i_cfg_wdata write the 7-bit deadband; write only while idle.
// quiet samples inside the band just extend the run and usually give no bytes.
// a sample is taken into the run state at acceptance and its bytes (one to three)
// are placed in a result register; the first byte is valid the next cycle.
// one byte leaves per cycle while the receiver is ready; an item makes no byte
// for a quiet sample that only extends the run, otherwise 1 to 3 bytes.
// i_in.ready is high while the result register is empty or its last byte is
// being taken, so samples follow back to back.
// when the receiver stalls, the current byte holds and the input stalls once
// the result register is occupied.
// synchronous reset sets deadband to 5 and clears the run, held sample and
// any pending bytes.
module deadband_rle_audio_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    dre_in_if.sink      i_in,
    dre_out_if.source   o_out
);
    import dre_pkg::*;

    t_grp grp;
    logic acc;
    logic free;

    assign i_in.ready = free;
    assign acc        = i_in.valid && free;

    dre_enc u_enc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (acc),
        .i_sample    (i_in.sample),
        .i_final     (i_in.final_sample),
        .o_grp       (grp)
    );

    dre_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (acc && (grp.cnt != 2'd0)),
        .i_grp       (grp),
        .i_out_ready (o_out.ready),
        .o_free      (free),
        .o_valid     (o_out.valid),
        .o_byte      (o_out.out_byte),
        .o_last      (o_out.last_of_item),
        .o_eos       (o_out.end_of_stream)
    );
endmodule

// ----- tb/deadband_rle_audio_encoder_unit_tb.sv -----
module deadband_rle_audio_encoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dre_pkg::*;

    typedef struct {
        logic [7:0] sample;
        logic       fin;
    } pcm_item_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       eos;
    } enc_byte_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;

    dre_in_if  in_if ();
    dre_out_if out_if ();

    deadband_rle_audio_encoder_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #1 i_clk = ~i_clk;

    pcm_item_t sample_q[$];
    enc_byte_t coded_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holds_asked = 0;
    int holds_given = 0;
    int hold_left = 0;
    int mismatches = 0;

    // encoder state as the block should hold it
    int         band_half = DeadbandReset;
    logic [7:0] quiet_run = '0;
    logic [7:0] held = '0;

    function automatic void encode_sample(input logic [7:0] s, input logic fin);
        logic [7:0] outs [0:2];
        int         n;
        enc_byte_t  eb;
        n = 0;
        if (!fin && int'(s) <= int'(QuietLevel) + band_half
                && int'(s) + band_half >= int'(QuietLevel)) begin
            quiet_run = quiet_run + 8'd1;
            held = s;
            if (quiet_run == RunFull) begin
                outs[0] = RunMarker;
                outs[1] = RunFull;
                n = 2;
                quiet_run = '0;
            end
        end else begin
            if (quiet_run == 8'd1) begin
                outs[0] = held;
                n = 1;
            end else if (quiet_run > 8'd1) begin
                outs[0] = RunMarker;
                outs[1] = quiet_run;
                n = 2;
            end
            quiet_run = '0;
            outs[n] = (s == RunMarker) ? ZeroEscape : s;
            n++;
            if (fin) begin
                held = '0;
            end
        end
        for (int i = 0; i < n; i++) begin
            eb.value = outs[i];
            eb.last  = (i == n - 1);
            eb.eos   = fin && (i == n - 1);
            coded_q.push_back(eb);
        end
    endfunction

    function automatic void push_sample(input logic [7:0] s, input logic fin);
        pcm_item_t it;
        it.sample = s;
        it.fin    = fin;
        sample_q.push_back(it);
    endfunction

    // quiet runs closed by a loud or final sample, with some noise mixed in
    function automatic void make_stream(input int budget, input int db, input bit long_runs);
        int         made;
        int         len;
        logic [7:0] s;
        bit         long_done;
        made = 0;
        long_done = 1'b0;
        while (made < budget) begin
            if ($urandom_range(99) < 15) begin
                push_sample(8'($urandom_range(255)), $urandom_range(19) == 0);
                made++;
            end else begin
                if (long_runs && !long_done) begin
                    len = 255 + $urandom_range(7);
                    long_done = 1'b1;
                end else begin
                    len = $urandom_range(6);
                end
                for (int k = 0; k < len; k++) begin
                    push_sample(8'(128 - db + $urandom_range(2 * db)), 1'b0);
                end
                made += len;
                if ($urandom_range(9) == 0) begin
                    push_sample(8'($urandom_range(255)), 1'b1);
                end else begin
                    do begin
                        s = 8'($urandom_range(255));
                    end while (int'(s) <= 128 + db && int'(s) + db >= 128);
                    push_sample(s, 1'b0);
                end
                made++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_if.valid        <= 1'b1;
                in_if.sample       <= sample_q[0].sample;
                in_if.final_sample <= sample_q[0].fin;
                void'(sample_q.pop_front());
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            encode_sample(in_if.sample, in_if.final_sample);
        end
    end

    always @(posedge i_clk) begin
        enc_byte_t want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (coded_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transaction byte=%02h last=%b eos=%b", $realtime,
                             out_if.out_byte, out_if.last_of_item, out_if.end_of_stream);
                end else begin
                    want = coded_q.pop_front();
                    if (out_if.out_byte !== want.value || out_if.last_of_item !== want.last
                            || out_if.end_of_stream !== want.eos) begin
                        mismatches++;
                        $display("%0t: expected byte=%02h last=%b eos=%b, got byte=%02h last=%b eos=%b",
                                 $realtime, want.value, want.last, want.eos, out_if.out_byte,
                                 out_if.last_of_item, out_if.end_of_stream);
                    end
                end
            end
            if (holds_asked != holds_given) begin
                holds_given++;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (sample_q.size() != 0 || in_if.valid || coded_q.size() != 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_deadband(input int v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= 7'(v);
        band_half = v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int db, input int idle, input int stall,
                             input int budget, input bit long_runs, input bit hold);
        wait_drained();
        write_deadband(db);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        make_stream(budget, db, long_runs);
        if (hold) begin
            holds_asked++;
        end
    endtask

    initial begin
        in_if.valid        = 1'b0;
        in_if.sample       = '0;
        in_if.final_sample = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // band edges, zero escape, run flushes and final samples at the reset deadband
        push_sample(8'h80, 1'b0);
        push_sample(8'h7b, 1'b0);
        push_sample(8'h85, 1'b0);
        push_sample(8'h7a, 1'b0);
        push_sample(8'h86, 1'b0);
        push_sample(8'h00, 1'b0);
        push_sample(8'hff, 1'b0);
        push_sample(8'h84, 1'b0);
        push_sample(8'h01, 1'b0);
        push_sample(8'h00, 1'b1);
        push_sample(8'h82, 1'b0);
        push_sample(8'h80, 1'b1);
        push_sample(8'h80, 1'b0);
        push_sample(8'h7f, 1'b0);
        push_sample(8'h00, 1'b1);
        push_sample(8'hff, 1'b1);
        push_sample(8'h7c, 1'b0);
        push_sample(8'h7e, 1'b1);
        push_sample(8'h81, 1'b0);

        run_phase(0, 0, 0, 30, 1'b0, 1'b0);
        run_phase(127, 85, 0, 30, 1'b0, 1'b0);
        run_phase($urandom_range(126, 1), 0, 85, 30, 1'b0, 1'b0);
        run_phase($urandom_range(126, 1), 14, 14, 30, 1'b0, 1'b0);
        run_phase(20, 0, 0, 30, 1'b0, 1'b1);
        run_phase($urandom_range(127), 0, 0, 260, 1'b1, 1'b0);

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && coded_q.size() == 0) begin
            $display("deadband_rle_audio_encoder_unit test passed");
        end else begin
            $display("deadband_rle_audio_encoder_unit test failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("deadband_rle_audio_encoder_unit test failed");
        $finish;
    end

endmodule
